### design/srde_pkg.sv
// Shared types and constants for the signed radix digit emitter.
package srde_pkg;

  localparam int MAG_W       = 32;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 5;
  localparam int ALPHA_W     = 64;
  localparam int MAX_DIGITS  = 32;
  localparam int SP_W        = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W       = $clog2(MAX_DIGITS);

  localparam logic [LEN_W-1:0]   MAX_RADIX   = 5'd16;
  localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2D;
  localparam logic [CHAR_W-1:0]  PLUS_CHAR   = 8'h2B;

  localparam logic [LEN_W-1:0]   RADIX_RESET = 5'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h0000000000003938;

  typedef enum logic [1:0] {
    REG_RADIX_LENGTH  = 2'd0,
    REG_ALPHABET_LOW  = 2'd1,
    REG_ALPHABET_HIGH = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] digit;
    logic               zero;
  } srde_div_stat_t;

endpackage

### design/signed_radix_digit_emitter.sv
// Digits are produced least significant first by the byte-serial divider and stacked.
// The stack is then emitted most significant digit first, after a minus sign if negative.
// One number is converted at a time; the next transfer is taken once emission ends.
// Synchronous reset clears control state and restores radix 10 with digits 0 to 9.
// An invalid alphabet produces no characters for the number.
module signed_radix_digit_emitter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [srde_pkg::ALPHA_W-1:0]    cfg_data,
  input  logic                            value_valid,
  output logic                            value_stall,
  input  logic signed [31:0]              value,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [srde_pkg::CHAR_W-1:0]     character,
  output logic                            last
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [srde_pkg::LEN_W-1:0]      radix_length;
  logic [srde_pkg::ALPHA_W-1:0]    alphabet_low;
  logic [srde_pkg::ALPHA_W-1:0]    alphabet_high;
  logic                            alpha_ok;
  logic                            neg;
  logic [srde_pkg::DIGIT_W-1:0]    stack [srde_pkg::MAX_DIGITS];
  logic [srde_pkg::SP_W-1:0]       sp;
  logic [srde_pkg::SP_W-1:0]       sp_dec;
  logic                            in_xfer;
  logic                            slot_free;
  logic                            go;
  logic [srde_pkg::MAG_W-1:0]      mag_in;
  srde_pkg::srde_div_stat_t        stat;

  function automatic logic [srde_pkg::CHAR_W-1:0] alpha_char(
    input logic [srde_pkg::DIGIT_W-1:0] idx,
    input logic [srde_pkg::ALPHA_W-1:0] lo,
    input logic [srde_pkg::ALPHA_W-1:0] hi
  );
    logic [5:0] pos;
    pos = {idx[2:0], 3'b000};
    return idx[3] ? hi[pos +: 8] : lo[pos +: 8];
  endfunction

  function automatic logic alphabet_ok(
    input logic [srde_pkg::LEN_W-1:0]   len,
    input logic [srde_pkg::ALPHA_W-1:0] lo,
    input logic [srde_pkg::ALPHA_W-1:0] hi
  );
    logic [srde_pkg::CHAR_W-1:0] ch [16];
    logic                        ok;
    for (int i = 0; i < 16; i++) begin
      ch[i] = alpha_char(4'(i), lo, hi);
    end
    ok = (len >= 5'd2) && (len <= srde_pkg::MAX_RADIX);
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < len) begin
        if (ch[i] == '0 || ch[i] == srde_pkg::MINUS_CHAR || ch[i] == srde_pkg::PLUS_CHAR) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < 16; j++) begin
          if (5'(j) < len && ch[j] == ch[i]) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_length  <= srde_pkg::RADIX_RESET;
      alphabet_low  <= srde_pkg::ALPHA_LOW_RESET;
      alphabet_high <= srde_pkg::ALPHA_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        srde_pkg::REG_RADIX_LENGTH:  radix_length  <= cfg_data[srde_pkg::LEN_W-1:0];
        srde_pkg::REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        srde_pkg::REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    alpha_ok <= alphabet_ok(radix_length, alphabet_low, alphabet_high);
  end

  assign value_stall = (state != ST_IDLE);
  assign in_xfer     = value_valid && !value_stall;
  assign slot_free   = !result_valid || !result_stall;
  assign mag_in      = value[31] ? (32'd0 - 32'(value)) : 32'(value);
  assign go          = (state == ST_CHECK && alpha_ok) ||
                       (state == ST_DIV && stat.done && !stat.zero);
  assign sp_dec      = sp - srde_pkg::SP_W'(1);

  srde_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (in_xfer),
    .load_mag (mag_in),
    .go       (go),
    .radix    (radix_length),
    .stat     (stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_CHECK;
      ST_CHECK: state_next = alpha_ok ? ST_DIV : ST_IDLE;
      ST_DIV:   if (stat.done && stat.zero) state_next = neg ? ST_SIGN : ST_EMIT;
      ST_SIGN:  if (slot_free) state_next = ST_EMIT;
      ST_EMIT:  if (slot_free && sp == srde_pkg::SP_W'(1)) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (in_xfer) begin
      sp <= '0;
    end else if (state == ST_DIV && stat.done) begin
      sp <= sp + srde_pkg::SP_W'(1);
    end else if (state == ST_EMIT && slot_free) begin
      sp <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg <= value[31];
    end
    if (state == ST_DIV && stat.done) begin
      stack[sp[srde_pkg::IDX_W-1:0]] <= stat.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (slot_free) begin
      result_valid <= (state == ST_SIGN) || (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && state == ST_SIGN) begin
      character <= srde_pkg::MINUS_CHAR;
      last      <= 1'b0;
    end else if (slot_free && state == ST_EMIT) begin
      character <= alpha_char(stack[sp_dec[srde_pkg::IDX_W-1:0]], alphabet_low, alphabet_high);
      last      <= (sp == srde_pkg::SP_W'(1));
    end
  end

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == ST_CHECK)
    else $error("accepted transfer did not enter the check state");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> sp != '0 && sp <= srde_pkg::SP_W'(srde_pkg::MAX_DIGITS))
    else $error("emit state with an empty or overfull digit stack");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && stat.done && !stat.zero |-> sp < srde_pkg::SP_W'(srde_pkg::MAX_DIGITS - 1))
    else $error("digit stack would overflow");
`endif

endmodule

### design/srde_divider.sv
// Byte-serial divider that peels off one radix digit of the magnitude each time it is started.
module srde_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [srde_pkg::MAG_W-1:0]     load_mag,
  input  logic                           go,
  input  logic [srde_pkg::LEN_W-1:0]     radix,
  output srde_pkg::srde_div_stat_t       stat
);

  logic [srde_pkg::MAG_W-1:0]   mag;
  logic [srde_pkg::DIGIT_W-1:0] rem;
  logic [1:0]                   cnt;
  logic                         busy;
  logic                         nz;

  logic [srde_pkg::DIGIT_W-1:0] part;
  logic [srde_pkg::DIGIT_W:0]   trial;
  logic [7:0]                   qbyte;

  // Restoring division of the top byte, carrying the remainder in.
  always_comb begin
    part  = rem;
    trial = '0;
    qbyte = '0;
    for (int i = 7; i >= 0; i--) begin
      trial = {part, mag[srde_pkg::MAG_W-8+i]};
      if (trial >= radix) begin
        part     = srde_pkg::DIGIT_W'(trial - radix);
        qbyte[i] = 1'b1;
      end else begin
        part = trial[srde_pkg::DIGIT_W-1:0];
      end
    end
  end

  assign stat.done  = busy && (cnt == 2'd3);
  assign stat.digit = part;
  assign stat.zero  = !(nz || (|qbyte));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (stat.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cnt <= '0;
      rem <= '0;
      nz  <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
      rem <= part;
      nz  <= nz || (|qbyte);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag <= load_mag;
    end else if (busy) begin
      mag <= {mag[srde_pkg::MAG_W-9:0], qbyte};
    end
  end

endmodule
